// ===== src/sm3_hash_compression_macros.svh =====
// Assertion helpers for the SM3 compression engine.
`ifndef SM3_HASH_COMPRESSION_MACROS_SVH
`define SM3_HASH_COMPRESSION_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SM3_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sm3 same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sm3 next-cycle check failed");

`endif

// ===== src/sm3_pkg.sv =====
`default_nettype none

package sm3_pkg;

   // Working variables A..H, index 0 holds A
   typedef logic [7:0][31:0] sm3_words_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_COLLECT = 3'b001,
      ST_ROUND   = 3'b010,
      ST_EMIT    = 3'b100
   } sm3_state_type;

   // Control from the sequencer to the message schedule
   typedef struct packed {
      logic        load;     // shift in a message word
      logic        advance;  // shift in an expanded word
      logic [31:0] word;
   } sm3_sched_ctrl_type;

   // Operands for one compression round
   typedef struct packed {
      logic [5:0]  round_idx;
      logic [31:0] w_j;
      logic [31:0] w_j4;
   } sm3_round_in_type;

   localparam logic [31:0] SM3_T_LOW  = 32'h79cc4519;
   localparam logic [31:0] SM3_T_HIGH = 32'h7a879d8a;
   localparam logic [5:0]  SM3_LAST_ROUND = 6'd63;
   localparam logic [3:0]  SM3_LAST_WORD  = 4'd15;
   localparam logic [2:0]  SM3_LAST_DIGEST = 3'd7;

   localparam sm3_words_type SM3_IV = {
      32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
      32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
   };

   // Rotate left by 0..31
   function automatic logic [31:0] sm3_rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] sm3_p0(input logic [31:0] x);
      return x ^ sm3_rotl(x, 5'd9) ^ sm3_rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] sm3_p1(input logic [31:0] x);
      return x ^ sm3_rotl(x, 5'd15) ^ sm3_rotl(x, 5'd23);
   endfunction

   // Round constant rotated by the round index modulo 32
   function automatic logic [31:0] sm3_tj(input logic [5:0] j);
      logic [31:0] t;
      t = (j[5:4] == 2'b00) ? SM3_T_LOW : SM3_T_HIGH;
      return sm3_rotl(t, j[4:0]);
   endfunction

endpackage

`default_nettype wire

// ===== src/sm3_msg_sched.sv =====
`default_nettype none

module sm3_msg_sched
   import sm3_pkg::*;
(
   input  wire logic               clock,
   input  wire sm3_sched_ctrl_type ctrl,
   output logic [31:0]             w_j,
   output logic [31:0]             w_j4
);

   logic [15:0][31:0] win_ff;
   logic [15:0][31:0] win_in;
   logic [31:0]       expand;

   // Form W[j+16] from the current window
   always_comb begin
      expand = sm3_p1(win_ff[0] ^ win_ff[7] ^ sm3_rotl(win_ff[13], 5'd15))
             ^ sm3_rotl(win_ff[3], 5'd7) ^ win_ff[10];
   end

   // Shift the window down, new word enters at the top
   always_comb begin
      win_in = win_ff;
      if (ctrl.load || ctrl.advance) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = ctrl.load ? ctrl.word : expand;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign w_j  = win_ff[0];
   assign w_j4 = win_ff[4];

endmodule

`default_nettype wire

// ===== src/sm3_round.sv =====
`default_nettype none

module sm3_round
   import sm3_pkg::*;
(
   input  wire sm3_words_type    v_cur,
   input  wire sm3_round_in_type op,
   output sm3_words_type         v_next
);

   logic [31:0] a12;
   logic [31:0] ss1;
   logic [31:0] ss2;
   logic [31:0] ff;
   logic [31:0] gg;
   logic [31:0] tt1;
   logic [31:0] tt2;
   logic        early;

   // One SM3 round
   always_comb begin
      early = (op.round_idx[5:4] == 2'b00);
      a12 = sm3_rotl(v_cur[0], 5'd12);
      ss1 = sm3_rotl(a12 + v_cur[4] + sm3_tj(op.round_idx), 5'd7);
      ss2 = ss1 ^ a12;
      ff  = early ? (v_cur[0] ^ v_cur[1] ^ v_cur[2])
                  : ((v_cur[0] & v_cur[1]) | (v_cur[0] & v_cur[2]) | (v_cur[1] & v_cur[2]));
      gg  = early ? (v_cur[4] ^ v_cur[5] ^ v_cur[6])
                  : ((v_cur[4] & v_cur[5]) | (~v_cur[4] & v_cur[6]));
      tt1 = ff + v_cur[3] + ss2 + (op.w_j ^ op.w_j4);
      tt2 = gg + v_cur[7] + ss1 + op.w_j;
      v_next[0] = tt1;
      v_next[1] = v_cur[0];
      v_next[2] = sm3_rotl(v_cur[1], 5'd9);
      v_next[3] = v_cur[2];
      v_next[4] = sm3_p0(tt2);
      v_next[5] = v_cur[4];
      v_next[6] = sm3_rotl(v_cur[5], 5'd19);
      v_next[7] = v_cur[6];
   end

endmodule

`default_nettype wire

// ===== src/sm3_hash_compression.sv =====
// Channel | Ports                                   | Direction
// req     | req_valid/req_stall, msg_word, flags    | in, one word per request
// rsp     | rsp_valid/rsp_stall, digest_word, last  | out, eight words per digest
//
// A block takes 16 request words, then 64 rounds in the single shared round unit.
// A last block adds the eight digest words, each held while rsp_stall is high.
// req_stall is high from the sixteenth word until the block is done.
// Reset is synchronous; the chaining value returns to the IV.
`default_nettype none

`include "sm3_hash_compression_macros.svh"

module sm3_hash_compression
   import sm3_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_msg_word,
   input  wire logic        req_first_block,
   input  wire logic        req_last_block,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic             rsp_digest_last
);

   sm3_state_type      state_ff, state_in;
   logic [3:0]         count_ff, count_in;
   logic [5:0]         round_ff, round_in;
   logic [2:0]         emit_ff, emit_in;
   logic               last_ff, last_in;
   sm3_words_type      chain_ff, chain_in;
   sm3_words_type      work_ff, work_in;
   sm3_words_type      round_out;
   sm3_sched_ctrl_type sched_ctrl;
   sm3_round_in_type   round_op;
   logic [31:0]        w_j;
   logic [31:0]        w_j4;
   logic               req_take;

   assign req_take = req_valid && !req_stall;

   // Message window and expansion
   always_comb begin
      sched_ctrl.load    = req_take;
      sched_ctrl.advance = (state_ff == ST_ROUND);
      sched_ctrl.word    = req_msg_word;
   end

   sm3_msg_sched u_sched (
      .clock (clock),
      .ctrl  (sched_ctrl),
      .w_j   (w_j),
      .w_j4  (w_j4)
   );

   // Shared round unit
   always_comb begin
      round_op.round_idx = round_ff;
      round_op.w_j       = w_j;
      round_op.w_j4      = w_j4;
   end

   sm3_round u_round (
      .v_cur  (work_ff),
      .op     (round_op),
      .v_next (round_out)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      round_in = round_ff;
      emit_in  = emit_ff;
      last_in  = last_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (req_take) begin
               count_in = count_ff + 4'd1;
               if (count_ff == SM3_LAST_WORD) begin
                  state_in = ST_ROUND;
                  round_in = '0;
                  last_in  = req_last_block;
                  if (req_first_block) begin
                     chain_in = SM3_IV;
                     work_in  = SM3_IV;
                  end else begin
                     work_in  = chain_ff;
                  end
               end
            end
         end
         ST_ROUND: begin
            work_in  = round_out;
            round_in = round_ff + 6'd1;
            if (round_ff == SM3_LAST_ROUND) begin
               chain_in = chain_ff ^ round_out;
               emit_in  = '0;
               state_in = last_ff ? ST_EMIT : ST_COLLECT;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               emit_in = emit_ff + 3'd1;
               if (emit_ff == SM3_LAST_DIGEST) begin
                  state_in = ST_COLLECT;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   // Hold control and chaining value under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         count_ff <= '0;
         round_ff <= '0;
         emit_ff  <= '0;
         last_ff  <= 1'b0;
         chain_ff <= SM3_IV;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         round_ff <= round_in;
         emit_ff  <= emit_in;
         last_ff  <= last_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   // Drive the handshake and digest
   assign req_stall       = (state_ff != ST_COLLECT);
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = chain_ff[emit_ff];
   assign rsp_digest_last = (emit_ff == SM3_LAST_DIGEST);

   `SM3_ASSERT_SAME(a_no_overlap, clock, reset, rsp_valid, req_stall)
   `SM3_ASSERT_SAME(a_count_idle, clock, reset, count_ff != 4'd0, state_ff == ST_COLLECT)
   `SM3_ASSERT_NEXT(a_round_end, clock, reset,
      state_ff == ST_ROUND && round_ff == SM3_LAST_ROUND, state_ff != ST_ROUND)
   `SM3_ASSERT_NEXT(a_emit_end, clock, reset,
      rsp_valid && !rsp_stall && rsp_digest_last, state_ff == ST_COLLECT)

endmodule

`default_nettype wire
